FILE: sv/ttcc_pkg.sv
// Shared types, character codes and helper functions for the terminal color parser.
package ttcc_pkg;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_UP_S = 8'h53;
  localparam logic [7:0] CH_UP_B = 8'h42;
  localparam logic [7:0] CH_UP_C = 8'h43;
  localparam logic [7:0] CH_LO_S = 8'h73;
  localparam logic [7:0] CH_LO_B = 8'h62;
  localparam logic [7:0] CH_LO_C = 8'h63;

  localparam int CMD_LEN = 8;
  localparam int HEX_DIGITS = 6;
  localparam logic [2:0] CMD_LAST = 3'(CMD_LEN - 1);
  localparam logic [2:0] CMD_FIRST_FILL = 3'd1;

  localparam logic ACT_GLYPH = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef struct packed {
    logic lf;
    logic cr;
    logic glyph;
    logic clear;
  } ttcc_ctl_t;

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] ch);
    logic [4:0] res;
    res = 5'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      res = {1'b1, 4'(ch - 8'h30)};
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      res = {1'b1, 4'(ch - 8'h41 + 8'd10)};
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      res = {1'b1, 4'(ch - 8'h61 + 8'd10)};
    end
    return res;
  endfunction

  function automatic logic [15:0] pack565(input logic [23:0] rgb);
    return {rgb[23:19], rgb[15:10], rgb[7:3]};
  endfunction

endpackage

FILE: sv/ttcc_cursor.sv
// Text cursor: column and row of the current glyph cell with line wrap.
module ttcc_cursor #(
  parameter int DISPLAY_WIDTH = 240,
  parameter int DISPLAY_HEIGHT = 320,
  parameter int GLYPH_SIZE = 16,
  localparam int COL_W = $clog2(DISPLAY_WIDTH + 2 * GLYPH_SIZE),
  localparam int ROW_W = $clog2(DISPLAY_HEIGHT + 2 * GLYPH_SIZE)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  ttcc_pkg::ttcc_ctl_t ctl,
  output logic [COL_W-1:0] col,
  output logic [ROW_W-1:0] row
);

  localparam logic [COL_W-1:0] G_COL = COL_W'(GLYPH_SIZE);
  localparam logic [ROW_W-1:0] G_ROW = ROW_W'(GLYPH_SIZE);
  localparam logic [COL_W-1:0] W_COL = COL_W'(DISPLAY_WIDTH);
  localparam logic [ROW_W-1:0] H_ROW = ROW_W'(DISPLAY_HEIGHT);

  logic [COL_W-1:0] col_r, col_nxt, col_adv;
  logic [ROW_W-1:0] row_r, row_nxt, row_dn, row_wrap;
  logic             wrap;

  always_comb begin
    col_adv  = col_r + G_COL;
    row_dn   = row_r + G_ROW;
    row_wrap = (row_dn + G_ROW >= H_ROW) ? '0 : row_dn;
    wrap     = (col_adv + G_COL >= W_COL);
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (step) begin
      if (ctl.lf) begin
        col_nxt = '0;
        row_nxt = row_wrap;
      end else if (ctl.cr) begin
        col_nxt = '0;
      end else if (ctl.glyph) begin
        if (wrap) begin
          col_nxt = '0;
          row_nxt = row_wrap;
        end else begin
          col_nxt = col_adv;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col = col_r;
  assign row = row_r;

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n) col_r < W_COL)
    else $error("cursor column out of range");
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n) row_r < H_ROW)
    else $error("cursor row out of range");
  a_line_ctl: assert property (@(posedge clk) disable iff (!rst_n)
    step && (ctl.lf || ctl.cr) |=> col_r == '0)
    else $error("line control did not zero column");

endmodule

FILE: sv/ttcc_cmd.sv
// Byte classifier and color command collector, decoder and color registers.
module ttcc_cmd #(
  parameter logic [15:0] TEXT_COLOR_AT_RESET = 16'hFFFF,
  parameter logic [15:0] BACKGROUND_COLOR_AT_RESET = 16'h0000
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  output ttcc_pkg::ttcc_ctl_t ctl,
  output logic [15:0]         fore_nxt,
  output logic [15:0]         back_nxt
);

  logic        in_cmd_r, in_cmd_nxt;
  logic [2:0]  fill_r, fill_nxt;
  logic [7:0]  chars_r [0:ttcc_pkg::CMD_LEN-2];
  logic [15:0] fore_r, back_r;
  logic        wr_char;
  logic [2:0]  wr_idx;
  logic        opener, done, is_sc, is_bc;
  logic [7:0]  digs [0:ttcc_pkg::HEX_DIGITS-1];
  logic [23:0] rgb;
  logic        run;
  logic [4:0]  hd;

  always_comb begin
    for (int i = 0; i < ttcc_pkg::HEX_DIGITS - 1; i++) begin
      digs[i] = chars_r[i+2];
    end
    digs[ttcc_pkg::HEX_DIGITS-1] = rx_byte;
    rgb = '0;
    run = 1'b1;
    hd  = '0;
    for (int i = 0; i < ttcc_pkg::HEX_DIGITS; i++) begin
      hd = ttcc_pkg::hex_digit(digs[i]);
      if (run && hd[4]) begin
        rgb = {rgb[19:0], hd[3:0]};
      end else begin
        run = 1'b0;
      end
    end
  end

  always_comb begin
    is_sc = (chars_r[0] == ttcc_pkg::CH_UP_S && chars_r[1] == ttcc_pkg::CH_UP_C) ||
            (chars_r[0] == ttcc_pkg::CH_LO_S && chars_r[1] == ttcc_pkg::CH_LO_C);
    is_bc = (chars_r[0] == ttcc_pkg::CH_UP_B && chars_r[1] == ttcc_pkg::CH_UP_C) ||
            (chars_r[0] == ttcc_pkg::CH_LO_B && chars_r[1] == ttcc_pkg::CH_LO_C);
    opener = (rx_byte == ttcc_pkg::CH_UP_S) || (rx_byte == ttcc_pkg::CH_UP_B) ||
             (rx_byte == ttcc_pkg::CH_LO_S) || (rx_byte == ttcc_pkg::CH_LO_B);
    ctl.lf    = (rx_byte == ttcc_pkg::CH_LF);
    ctl.cr    = (rx_byte == ttcc_pkg::CH_CR);
    ctl.glyph = 1'b0;
    ctl.clear = 1'b0;
    done       = 1'b0;
    in_cmd_nxt = in_cmd_r;
    fill_nxt   = fill_r;
    wr_char    = 1'b0;
    wr_idx     = fill_r;
    fore_nxt   = fore_r;
    back_nxt   = back_r;
    if (!ctl.lf && !ctl.cr) begin
      if (!in_cmd_r) begin
        if (opener) begin
          in_cmd_nxt = 1'b1;
          fill_nxt   = ttcc_pkg::CMD_FIRST_FILL;
          wr_char    = 1'b1;
          wr_idx     = '0;
        end else begin
          ctl.glyph = 1'b1;
        end
      end else if (fill_r == ttcc_pkg::CMD_LAST) begin
        done       = 1'b1;
        in_cmd_nxt = 1'b0;
        fill_nxt   = '0;
      end else begin
        wr_char  = 1'b1;
        fill_nxt = fill_r + 3'd1;
      end
    end
    if (done && is_sc) begin
      fore_nxt = ttcc_pkg::pack565(rgb);
    end
    if (done && is_bc) begin
      back_nxt  = ttcc_pkg::pack565(rgb);
      ctl.clear = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cmd_r <= 1'b0;
      fill_r   <= '0;
      fore_r   <= TEXT_COLOR_AT_RESET;
      back_r   <= BACKGROUND_COLOR_AT_RESET;
    end else if (step) begin
      in_cmd_r <= in_cmd_nxt;
      fill_r   <= fill_nxt;
      fore_r   <= fore_nxt;
      back_r   <= back_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && wr_char) begin
      chars_r[wr_idx] <= rx_byte;
    end
  end

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.glyph && ctl.clear))
    else $error("glyph and clear at once");
  a_fill_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_cmd_r |-> fill_r == '0)
    else $error("fill count nonzero outside command");
  a_open: assert property (@(posedge clk) disable iff (!rst_n)
    step && !in_cmd_r && opener && !ctl.lf && !ctl.cr |=> in_cmd_r)
    else $error("command did not open");

endmodule

FILE: sv/text_terminal_color_command_parser.sv
// Top level of the character terminal byte parser with color commands.
// Input channel: in_valid/in_stall carry one received byte (in_rx_byte) per item.
// Output channel: out_valid/out_stall carry at most one result per input item:
//   a draw-glyph result (out_action 0) with cell position and both colors, or
//   a fill-screen result (out_action 1) after a background color command.
// Line feed, carriage return and command bytes give no result but the fill-screen.
// Path: a byte is held in an input register, then classified, cursor and colors
// updated and the result written to the output register.
// Throughput: one byte per cycle when not stalled, set by the single-pass update
// of the cursor and command registers between the input and output registers.
// When out_stall holds a waiting result, the byte in the input register waits
// and, once that register is full, in_stall rises; bytes that give no result
// also wait until the output register is free.
// Reset (rst_n low, synchronous) clears the cursor, leaves command mode and
// loads the reset colors; both channels come up empty.
module text_terminal_color_command_parser #(
  parameter int DISPLAY_WIDTH = 240,
  parameter int DISPLAY_HEIGHT = 320,
  parameter int GLYPH_SIZE = 16,
  parameter int TEXT_COLOR_AT_RESET = 65535,
  parameter int BACKGROUND_COLOR_AT_RESET = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_action,
  output logic [7:0]  out_glyph_code,
  output logic [7:0]  out_pixel_x,
  output logic [8:0]  out_pixel_y,
  output logic [15:0] out_fore_color,
  output logic [15:0] out_back_color
);

  localparam int COL_W = $clog2(DISPLAY_WIDTH + 2 * GLYPH_SIZE);
  localparam int ROW_W = $clog2(DISPLAY_HEIGHT + 2 * GLYPH_SIZE);

  logic        s1_v_r, s1_v_nxt;
  logic [7:0]  s1_byte_r;
  logic        adv, fire, take;
  ttcc_pkg::ttcc_ctl_t ctl;
  logic [15:0] fore_nxt, back_nxt;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [31:0] col_ext, row_ext;

  logic        out_valid_r, out_valid_nxt;
  logic        out_action_r;
  logic [7:0]  out_glyph_r, out_x_r;
  logic [8:0]  out_y_r;
  logic [15:0] out_fore_r, out_back_r;

  assign adv      = !out_valid_r || !out_stall;
  assign fire     = s1_v_r && adv;
  assign in_stall = s1_v_r && !adv;
  assign take     = in_valid && !in_stall;
  assign s1_v_nxt = take || (s1_v_r && !fire);
  assign out_valid_nxt = fire ? (ctl.glyph || ctl.clear) : (out_valid_r && !adv);
  assign col_ext  = 32'(col);
  assign row_ext  = 32'(row);

  ttcc_cmd #(
    .TEXT_COLOR_AT_RESET       (16'(TEXT_COLOR_AT_RESET)),
    .BACKGROUND_COLOR_AT_RESET (16'(BACKGROUND_COLOR_AT_RESET))
  ) u_cmd (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (fire),
    .rx_byte  (s1_byte_r),
    .ctl      (ctl),
    .fore_nxt (fore_nxt),
    .back_nxt (back_nxt)
  );

  ttcc_cursor #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
    .GLYPH_SIZE     (GLYPH_SIZE)
  ) u_cursor (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (fire),
    .ctl   (ctl),
    .col   (col),
    .row   (row)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_byte_r <= in_rx_byte;
    end
    if (fire) begin
      out_fore_r <= fore_nxt;
      out_back_r <= back_nxt;
      if (ctl.clear) begin
        out_action_r <= ttcc_pkg::ACT_CLEAR;
        out_glyph_r  <= '0;
        out_x_r      <= '0;
        out_y_r      <= '0;
      end else begin
        out_action_r <= ttcc_pkg::ACT_GLYPH;
        out_glyph_r  <= s1_byte_r;
        out_x_r      <= col_ext[7:0];
        out_y_r      <= row_ext[8:0];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_action     = out_action_r;
  assign out_glyph_code = out_glyph_r;
  assign out_pixel_x    = out_x_r;
  assign out_pixel_y    = out_y_r;
  assign out_fore_color = out_fore_r;
  assign out_back_color = out_back_r;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !fire)
    else $error("stage advanced into a stalled output");
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_action_r == ttcc_pkg::ACT_CLEAR |->
      out_glyph_r == '0 && out_x_r == '0 && out_y_r == '0)
    else $error("fill-screen result carries position");
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (ctl.glyph || ctl.clear) |=> out_valid_r)
    else $error("result lost");

endmodule
